[rtl/va_pkg.sv]
// Shared types, constants and saturation helper for the 3-vector ALU.
`timescale 1ns / 1ps
package va_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int SIDE_DEPTH = SQRT_STEPS + DIV_STEPS + 1;
    localparam int FRAC_BITS  = 16;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_DOT   = 3'd2,
        OP_CROSS = 3'd3,
        OP_MAG   = 3'd4,
        OP_NORM  = 3'd5,
        OP_SCALE = 3'd6
    } t_op;

    typedef struct packed {
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [32:0] sum;
        logic signed [31:0] a;
    } t_lane_res;

    typedef struct packed {
        t_op              op;
        logic [2:0][31:0] vec;
        logic [2:0][31:0] a;
        logic [31:0]      scalar;
        logic             sat;
    } t_side;

    typedef struct packed {
        logic        flag;
        logic [31:0] val;
    } t_sat;

    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat r;
        if (v > 66'sd2147483647) begin
            r.flag = 1'b1;
            r.val  = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r.flag = 1'b1;
            r.val  = 32'h8000_0000;
        end else begin
            r.flag = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/va_lane.sv]
// One component lane: operand select, two multipliers and add/subtract, registered.
`timescale 1ns / 1ps
module va_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  va_pkg::t_op        i_op,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic signed [31:0] i_s,
    input  logic signed [31:0] i_cl0,
    input  logic signed [31:0] i_cr0,
    input  logic signed [31:0] i_cl1,
    input  logic signed [31:0] i_cr1,
    output va_pkg::t_lane_res  o_res
);
    logic signed [31:0] m0a;
    logic signed [31:0] m0b;
    va_pkg::t_lane_res  r_res;

    always_comb begin
        case (i_op)
            va_pkg::OP_DOT: begin
                m0a = i_a;
                m0b = i_b;
            end
            va_pkg::OP_CROSS: begin
                m0a = i_cl0;
                m0b = i_cr0;
            end
            va_pkg::OP_SCALE: begin
                m0a = i_a;
                m0b = i_s;
            end
            default: begin
                m0a = i_a;
                m0b = i_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.p0 <= 64'(m0a) * 64'(m0b);
            r_res.p1 <= 64'(i_cl1) * 64'(i_cr1);
            r_res.sum <= (i_op == va_pkg::OP_SUB) ? (33'(i_a) - 33'(i_b))
                                                  : (33'(i_a) + 33'(i_b));
            r_res.a <= i_a;
        end
    end

    assign o_res = r_res;
endmodule

[rtl/va_isqrt.sv]
// Pipelined floor square root of a 64-bit value, one result bit per stage.
`timescale 1ns / 1ps
module va_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_n,
    output logic [31:0] o_root
);
    localparam int N = va_pkg::SQRT_STEPS;

    logic [63:0] r_n [N];
    logic [63:0] r_r [N];
    wire  [63:0] s_n [N];
    wire  [63:0] s_r [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        logic        ge;
        if (k == 0) begin : g_first
            assign s_n[k] = i_n;
            assign s_r[k] = '0;
        end else begin : g_next
            assign s_n[k] = r_n[k-1];
            assign s_r[k] = r_r[k-1];
        end
        assign trial = s_r[k] + BIT;
        assign ge    = (s_n[k] >= trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k] <= ge ? (s_n[k] - trial) : s_n[k];
                r_r[k] <= ge ? ((s_r[k] >> 1) + BIT) : (s_r[k] >> 1);
            end
        end
    end

    assign o_root = r_r[N-1][31:0];
endmodule

[rtl/va_div.sv]
// Pipelined truncating Q16.16 divide of one component by the magnitude.
`timescale 1ns / 1ps
module va_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic        [31:0] i_m,
    output logic signed [31:0] o_q,
    output logic        [31:0] o_m
);
    localparam int N  = va_pkg::DIV_STEPS;
    localparam int RW = 32 + va_pkg::FRAC_BITS;

    logic [RW-1:0] r_rem [N];
    logic [N-1:0]  r_q   [N];
    logic [31:0]   r_m   [N];
    logic          r_neg [N];
    wire  [RW-1:0] s_rem [N];
    wire  [N-1:0]  s_q   [N];
    wire  [31:0]   s_m   [N];
    wire           s_neg [N];
    logic [31:0]   mag;

    assign mag = i_a[31] ? (32'd0 - i_a) : i_a;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [RW-1:0] cand;
        logic          ge;
        if (k == 0) begin : g_first
            assign s_rem[k] = {mag, {va_pkg::FRAC_BITS{1'b0}}};
            assign s_q[k]   = '0;
            assign s_m[k]   = i_m;
            assign s_neg[k] = i_a[31];
        end else begin : g_next
            assign s_rem[k] = r_rem[k-1];
            assign s_q[k]   = r_q[k-1];
            assign s_m[k]   = r_m[k-1];
            assign s_neg[k] = r_neg[k-1];
        end
        assign cand = RW'(s_m[k]) << (N - 1 - k);
        assign ge   = (s_rem[k] >= cand);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? (s_rem[k] - cand) : s_rem[k];
                r_q[k]   <= {s_q[k][N-2:0], ge};
                r_m[k]   <= s_m[k];
                r_neg[k] <= s_neg[k];
            end
        end
    end

    assign o_q = r_neg[N-1] ? (32'd0 - 32'(r_q[N-1])) : 32'(r_q[N-1]);
    assign o_m = r_m[N-1];
endmodule

[rtl/vector3_alu_core.sv]
// Top level of the Q16.16 3-vector ALU: lanes, merge stage, root and divide pipes.
//
// Usage: one transaction on the input channel (i_in_valid/o_in_ready) carries
// an operation code, vectors a and b and a scale factor; exactly one result
// transaction follows on the output channel (o_out_valid/i_out_ready).
// Results come out in order.
// Each transaction passes the product stage, the merge stage, 32 square-root
// stages, 17 divide stages and the output register. Every operation takes
// the same path.
// Throughput: one transaction per cycle unless stalled; the pipeline is fully pipelined.
// Stall: when a result waits and i_out_ready is low, the whole pipeline
// holds and o_in_ready drops in the same cycle; nothing is lost.
// Reset: i_rst_n low clears all valid flags; payload registers are not reset.
`timescale 1ns / 1ps
module vector3_alu_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic        [2:0]  i_operation,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_scale_factor,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result_x,
    output logic signed [31:0] o_result_y,
    output logic signed [31:0] o_result_z,
    output logic signed [31:0] o_result_scalar,
    output logic               o_saturated
);
    localparam int SD = va_pkg::SIDE_DEPTH;

    logic              adv;
    va_pkg::t_op       op_in;
    va_pkg::t_op       r_op1;
    va_pkg::t_lane_res lane [3];
    logic [SD:0]       r_vld;
    logic              r_out_valid;
    va_pkg::t_side     n_side;
    va_pkg::t_side     r_side [SD];
    logic [63:0]       n_sumsq;
    logic [63:0]       r_sumsq;
    logic [31:0]       root;
    logic [31:0]       m_dly [3];
    logic signed [31:0] quo [3];
    va_pkg::t_side     fin;
    logic [31:0]       r_rx, r_ry, r_rz, r_rs;
    logic              r_sat;
    logic [2:0][31:0]  n_vec;
    logic [31:0]       n_scalar;
    logic              n_sat;

    assign adv   = !r_out_valid || i_out_ready;
    assign op_in = va_pkg::t_op'(i_operation);

    va_lane u_lane_x (
        .i_clk(i_clk), .i_en(adv), .i_op(op_in),
        .i_a(i_a_x), .i_b(i_b_x), .i_s(i_scale_factor),
        .i_cl0(i_a_y), .i_cr0(i_b_z), .i_cl1(i_a_z), .i_cr1(i_b_y),
        .o_res(lane[0])
    );
    va_lane u_lane_y (
        .i_clk(i_clk), .i_en(adv), .i_op(op_in),
        .i_a(i_a_y), .i_b(i_b_y), .i_s(i_scale_factor),
        .i_cl0(i_a_z), .i_cr0(i_b_x), .i_cl1(i_a_x), .i_cr1(i_b_z),
        .o_res(lane[1])
    );
    va_lane u_lane_z (
        .i_clk(i_clk), .i_en(adv), .i_op(op_in),
        .i_a(i_a_z), .i_b(i_b_z), .i_s(i_scale_factor),
        .i_cl0(i_a_x), .i_cr0(i_b_y), .i_cl1(i_a_y), .i_cr1(i_b_x),
        .o_res(lane[2])
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_op1 <= op_in;
        end
    end

    // merge stage
    always_comb begin
        va_pkg::t_sat       s;
        logic signed [65:0] w;
        n_side.op     = r_op1;
        n_side.sat    = 1'b0;
        n_side.scalar = '0;
        for (int i = 0; i < 3; i++) begin
            n_side.a[i] = lane[i].a;
            case (r_op1) inside
                va_pkg::OP_ADD, va_pkg::OP_SUB: w = 66'(lane[i].sum);
                va_pkg::OP_CROSS: w = (66'(lane[i].p0) - 66'(lane[i].p1)) >>> 16;
                va_pkg::OP_SCALE: w = 66'(lane[i].p0) >>> 16;
                default:          w = '0;
            endcase
            s = va_pkg::sat32(w);
            n_side.vec[i] = s.val;
            n_side.sat    = n_side.sat | s.flag;
        end
        if (r_op1 == va_pkg::OP_DOT) begin
            w = (66'(lane[0].p0) + 66'(lane[1].p0) + 66'(lane[2].p0)) >>> 16;
            s = va_pkg::sat32(w);
            n_side.scalar = s.val;
            n_side.sat    = s.flag;
        end
        n_sumsq = lane[0].p0[63:0] + lane[1].p0[63:0] + lane[2].p0[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            r_sumsq   <= n_sumsq;
            for (int k = 1; k < SD; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    va_isqrt u_isqrt (
        .i_clk(i_clk), .i_en(adv), .i_n(r_sumsq), .o_root(root)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        va_div u_div (
            .i_clk(i_clk), .i_en(adv),
            .i_a(r_side[va_pkg::SQRT_STEPS].a[i]), .i_m(root),
            .o_q(quo[i]), .o_m(m_dly[i])
        );
    end

    assign fin = r_side[SD-1];

    always_comb begin
        n_vec    = fin.vec;
        n_scalar = fin.scalar;
        n_sat    = fin.sat;
        case (fin.op)
            va_pkg::OP_MAG: begin
                n_vec    = '0;
                n_scalar = m_dly[0][31] ? 32'h7FFF_FFFF : m_dly[0];
                n_sat    = m_dly[0][31];
            end
            va_pkg::OP_NORM: begin
                n_scalar = '0;
                n_sat    = 1'b0;
                if (m_dly[0] == '0) begin
                    n_vec = fin.a;
                end else begin
                    n_vec = {quo[2], quo[1], quo[0]};
                end
            end
            default: begin
                n_vec    = fin.vec;
                n_scalar = fin.scalar;
                n_sat    = fin.sat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[SD-1:0], i_in_valid};
            r_out_valid <= r_vld[SD];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rx  <= n_vec[0];
            r_ry  <= n_vec[1];
            r_rz  <= n_vec[2];
            r_rs  <= n_scalar;
            r_sat <= n_sat;
        end
    end

    assign o_in_ready      = adv;
    assign o_out_valid     = r_out_valid;
    assign o_result_x      = r_rx;
    assign o_result_y      = r_ry;
    assign o_result_z      = r_rz;
    assign o_result_scalar = r_rs;
    assign o_saturated     = r_sat;
endmodule

[rtl/va_checker.sv]
// Port-level assertions for the 3-vector ALU, bound to the top level.
`timescale 1ns / 1ps
module va_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_result_x,
    input logic signed [31:0] o_result_y,
    input logic signed [31:0] o_result_z,
    input logic signed [31:0] o_result_scalar,
    input logic               o_saturated
);
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not track output stall");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_x)
            && $stable(o_result_scalar) && $stable(o_saturated))
        else $error("result changed while stalled");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_result_x == 32'sh7FFFFFFF || o_result_x == 32'sh80000000 ||
            o_result_y == 32'sh7FFFFFFF || o_result_y == 32'sh80000000 ||
            o_result_z == 32'sh7FFFFFFF || o_result_z == 32'sh80000000 ||
            o_result_scalar == 32'sh7FFFFFFF || o_result_scalar == 32'sh80000000)
        else $error("saturation flag without clamped value");
endmodule

bind vector3_alu_core va_checker u_va_checker (.*);
